/* sv/dbt_pkg.sv */
// Package for the byte tokenizer: scan phases, token kinds, error codes, constants.
// No dependencies.
`default_nettype none
package dbt_pkg;

  localparam int OffsetWidthDefault = 32;
  localparam int NumberLimitDefault = 64;
  localparam int KindWidth = 6;
  localparam int ValueWidth = 63;
  localparam int LengthWidth = 7;
  localparam int KwBytes = 7;
  localparam logic [ValueWidth-1:0] ValueMax = '1;
  localparam logic [LengthWidth-1:0] LengthMax = '1;

  typedef enum logic [14:0] {
    PH_TRIVIA       = 15'h0001,
    PH_SLASH        = 15'h0002,
    PH_LINE         = 15'h0004,
    PH_BLOCK        = 15'h0008,
    PH_BLOCK_STAR   = 15'h0010,
    PH_IDENT        = 15'h0020,
    PH_STRING       = 15'h0040,
    PH_STR_ESC      = 15'h0080,
    PH_NUM_ZERO     = 15'h0100,
    PH_NUM_DEC      = 15'h0200,
    PH_NUM_HEX      = 15'h0400,
    PH_NUM_FRAC     = 15'h0800,
    PH_NUM_EXP_SIGN = 15'h1000,
    PH_NUM_EXP      = 15'h2000,
    PH_OP           = 15'h4000
  } phase_t;

  localparam logic [5:0] K_EOF = 6'd0;
  localparam logic [5:0] K_INVALID = 6'd1;
  localparam logic [5:0] K_IDENT = 6'd2;
  localparam logic [5:0] K_STRING = 6'd3;
  localparam logic [5:0] K_INT = 6'd4;
  localparam logic [5:0] K_FLOAT = 6'd5;
  localparam logic [5:0] K_FIRST_KW = 6'd6;
  localparam logic [5:0] K_TRUE = 6'd16;
  localparam logic [5:0] K_LBRACE = 6'd20;
  localparam logic [5:0] K_RBRACE = 6'd21;
  localparam logic [5:0] K_LPAREN = 6'd22;
  localparam logic [5:0] K_RPAREN = 6'd23;
  localparam logic [5:0] K_LBRACK = 6'd24;
  localparam logic [5:0] K_RBRACK = 6'd25;
  localparam logic [5:0] K_COMMA = 6'd26;
  localparam logic [5:0] K_SEMI = 6'd27;
  localparam logic [5:0] K_DOT = 6'd28;
  localparam logic [5:0] K_ARROW = 6'd29;
  localparam logic [5:0] K_COLON = 6'd30;
  localparam logic [5:0] K_STAR = 6'd31;
  localparam logic [5:0] K_EQEQ = 6'd32;
  localparam logic [5:0] K_NE = 6'd33;
  localparam logic [5:0] K_LT = 6'd34;
  localparam logic [5:0] K_LE = 6'd35;
  localparam logic [5:0] K_GT = 6'd36;
  localparam logic [5:0] K_GE = 6'd37;
  localparam logic [5:0] K_PLUS = 6'd38;
  localparam logic [5:0] K_MINUS = 6'd39;
  localparam logic [5:0] K_SLASH = 6'd40;
  localparam logic [5:0] K_PERCENT = 6'd41;
  localparam logic [5:0] K_BANG = 6'd42;
  localparam logic [5:0] K_ANDAND = 6'd43;
  localparam logic [5:0] K_OROR = 6'd44;
  localparam logic [5:0] K_ASSIGN = 6'd45;

  localparam logic [1:0] E_NONE = 2'd0;
  localparam logic [1:0] E_UNTERM = 2'd1;
  localparam logic [1:0] E_NUMBER = 2'd2;
  localparam logic [1:0] E_CHAR = 2'd3;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_END = 1'b1;

  // Keyword text, low byte first, and lengths.
  function automatic logic [55:0] kw_text(input logic [3:0] i);
    case (i)
      4'd0:    kw_text = 56'h656c7572;
      4'd1:    kw_text = 56'h776f6c6c61;
      4'd2:    kw_text = 56'h796e6564;
      4'd3:    kw_text = 56'h65726975716572;
      4'd4:    kw_text = 56'h746867696577;
      4'd5:    kw_text = 56'h6e6f73616572;
      4'd6:    kw_text = 56'h68746977;
      4'd7:    kw_text = 56'h646e61;
      4'd8:    kw_text = 56'h726f;
      4'd9:    kw_text = 56'h746f6e;
      4'd10:   kw_text = 56'h65757274;
      4'd11:   kw_text = 56'h65736c6166;
      4'd12:   kw_text = 56'h6669;
      4'd13:   kw_text = 56'h65736c65;
      default: kw_text = '0;
    endcase
  endfunction

  function automatic logic [2:0] kw_len(input logic [3:0] i);
    case (i)
      4'd0, 4'd2, 4'd6, 4'd10, 4'd13: kw_len = 3'd4;
      4'd1, 4'd11:                    kw_len = 3'd5;
      4'd3:                           kw_len = 3'd7;
      4'd4, 4'd5:                     kw_len = 3'd6;
      4'd7, 4'd9:                     kw_len = 3'd3;
      default:                        kw_len = 3'd2;
    endcase
  endfunction

  typedef struct packed {
    logic [KindWidth-1:0]  kind;
    logic [ValueWidth-1:0] value;
    logic [1:0]            err;
  } tok_info_t;

endpackage
`default_nettype wire

/* sv/dbt_stream_if.sv */
// Valid/ready stream interfaces for the tokenizer's input and result channels.
// Depends on nothing.
`default_nettype none
interface dbt_in_if (input logic clk);
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] byte_in;
  modport source (output valid, mode, byte_in, input ready);
  modport sink (input valid, mode, byte_in, output ready);
endinterface

interface dbt_out_if #(parameter int OFFSET_WIDTH = 32) (input logic clk);
  logic                    valid;
  logic                    ready;
  logic [5:0]              token_kind;
  logic [OFFSET_WIDTH-1:0] span_begin;
  logic [OFFSET_WIDTH-1:0] span_end;
  logic [62:0]             int_value;
  logic [1:0]              error_code;
  logic                    last_of_run;
  modport source (output valid, token_kind, span_begin, span_end, int_value, error_code,
                  last_of_run, input ready);
  modport sink (input valid, token_kind, span_begin, span_end, int_value, error_code,
                last_of_run, output ready);
endinterface
`default_nettype wire

/* sv/dsl_byte_tokenizer.sv */
// Byte tokenizer top level: input register, scanner, two two-entry result queues.
// Depends on dbt_pkg, dbt_stream_if, dbt_scanner and dbt_out_fifo.
//
// The tokenizer takes one source byte or end marker per cycle while its input is
// ready, and gives zero, one or two token transactions for it. An accepted byte sits
// in the input register while the scanner decides its tokens; those enter two
// interleaved two-entry queues, four entries in all, that feed the result channel.
// Bytes stream at one per cycle as long as the result side drains; the input stalls
// only while the queued tokens plus the tokens of the byte in flight exceed two,
// which keeps room for the two tokens the next byte may give. The first token of a
// byte is offered once it has passed the input register and a result queue.
`default_nettype none
module dsl_byte_tokenizer #(
  parameter int OFFSET_WIDTH = dbt_pkg::OffsetWidthDefault,
  parameter int NUMBER_LIMIT = dbt_pkg::NumberLimitDefault
) (
  input logic clk,
  input logic rst,
  dbt_in_if.sink   in_ch,
  dbt_out_if.source out_ch
);
  import dbt_pkg::*;

  localparam int EntryWidth = KindWidth + 2 * OFFSET_WIDTH + ValueWidth + 2 + 1;

  logic                    stage_valid;
  logic                    stage_mode;
  logic [7:0]              stage_byte;
  logic [1:0]              n_out;
  tok_info_t               t0, t1;
  logic [OFFSET_WIDTH-1:0] b0, e0, b1, e1;
  logic [1:0]              c0, c1;
  logic                    q0_wr, q1_wr;
  logic                    q0_valid, q1_valid;
  logic [EntryWidth-1:0]   q0_data, q1_data;
  logic                    q_sel;
  logic [EntryWidth-1:0]   out_data;
  logic                    go;
  logic                    rd0, rd1;

  // Results are written into two queues in turn; q_sel points at the older head.
  // Space: queued tokens plus those of the staged byte must leave two of the four
  // entries free for the byte accepted now.
  assign go = stage_valid;
  assign in_ch.ready = ({1'b0, c0} + {1'b0, c1} + (go ? {1'b0, n_out} : 3'd0)) <= 3'd2;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) stage_valid <= 1'b0;
    else stage_valid <= in_ch.valid && in_ch.ready;
  end
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stage_mode <= in_ch.mode;
      stage_byte <= in_ch.byte_in;
    end
  end

  dbt_scanner #(.OFFSET_WIDTH(OFFSET_WIDTH), .NUMBER_LIMIT(NUMBER_LIMIT)) u_scan (
    .clk(clk), .rst(rst), .go(go), .mode(stage_mode), .c(stage_byte), .n_out(n_out),
    .t0(t0), .b0(b0), .e0(e0), .t1(t1), .b1(b1), .e1(e1)
  );

  // Write pointer alternates between the two queues so order is kept.
  logic wsel;
  always_ff @(posedge clk) begin
    if (rst) wsel <= 1'b0;
    else if (go && n_out == 2'd1) wsel <= ~wsel;
  end
  always_ff @(posedge clk) begin
    if (rst) q_sel <= 1'b0;
    else if (out_ch.valid && out_ch.ready) q_sel <= ~q_sel;
  end

  logic [EntryWidth-1:0] ent0, ent1;
  assign ent0 = {t0.kind, b0, e0, t0.value, t0.err, n_out == 2'd1};
  assign ent1 = {t1.kind, b1, e1, t1.value, t1.err, 1'b1};
  assign q0_wr = go && n_out != 2'd0 && (n_out == 2'd2 || !wsel);
  assign q1_wr = go && n_out != 2'd0 && (n_out == 2'd2 || wsel);

  logic [EntryWidth-1:0] w0, w1;
  assign w0 = (n_out == 2'd2) ? (wsel ? ent1 : ent0) : ent0;
  assign w1 = (n_out == 2'd2) ? (wsel ? ent0 : ent1) : ent0;

  assign rd0 = out_ch.valid && out_ch.ready && !q_sel;
  assign rd1 = out_ch.valid && out_ch.ready && q_sel;

  dbt_out_fifo #(.Width(EntryWidth)) u_q0 (
    .clk(clk), .rst(rst), .wr_en(q0_wr), .wr_data(w0), .count(c0),
    .rd_valid(q0_valid), .rd_data(q0_data), .rd_en(rd0)
  );
  dbt_out_fifo #(.Width(EntryWidth)) u_q1 (
    .clk(clk), .rst(rst), .wr_en(q1_wr), .wr_data(w1), .count(c1),
    .rd_valid(q1_valid), .rd_data(q1_data), .rd_en(rd1)
  );

  // Result channel.
  assign out_data = q_sel ? q1_data : q0_data;
  assign out_ch.valid = q_sel ? q1_valid : q0_valid;
  assign {out_ch.token_kind, out_ch.span_begin, out_ch.span_end, out_ch.int_value,
          out_ch.error_code, out_ch.last_of_run} = out_data;
endmodule
`default_nettype wire

/* sv/dbt_kw_match.sv */
// Keyword matcher: compares the 7-byte identifier buffer with the keyword table.
// Depends on dbt_pkg.
`default_nettype none
module dbt_kw_match (
  input  logic [55:0] buffer,
  input  logic [6:0]  length,
  output logic [5:0]  kind
);
  import dbt_pkg::*;

  // Fourteen independent compares; the lowest-numbered hit wins.
  always_comb begin
    kind = K_IDENT;
    for (int i = 13; i >= 0; i--) begin
      logic [55:0] mask;
      logic [2:0]  len;
      len = kw_len(4'(i));
      mask = (56'd1 << (6'(len) * 6'd8)) - 56'd1;
      if (length == 7'(len) && ((buffer & mask) == kw_text(4'(i)))) begin
        kind = K_FIRST_KW + 6'(i);
      end
    end
  end
endmodule
`default_nettype wire

/* sv/dbt_out_fifo.sv */
// Two-entry result queue between the scanner and the output channel.
// No dependencies.
`default_nettype none
module dbt_out_fifo #(
  parameter int Width = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [Width-1:0] wr_data,
  output logic [1:0]       count,
  output logic             rd_valid,
  output logic [Width-1:0] rd_data,
  input  logic             rd_en
);
  logic [Width-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;

  assign rd_valid = count != 2'd0;
  assign rd_data  = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      count <= count + 2'(wr_en) - 2'(rd_en);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end
endmodule
`default_nettype wire

/* sv/dbt_scanner.sv */
// Scanner core: lexer state registers and token decisions for the staged byte.
// Depends on dbt_pkg and dbt_kw_match.
`default_nettype none
module dbt_scanner #(
  parameter int OFFSET_WIDTH = dbt_pkg::OffsetWidthDefault,
  parameter int NUMBER_LIMIT = dbt_pkg::NumberLimitDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    go,
  input  logic                    mode,
  input  logic [7:0]              c,
  output logic [1:0]              n_out,
  output dbt_pkg::tok_info_t      t0,
  output logic [OFFSET_WIDTH-1:0] b0,
  output logic [OFFSET_WIDTH-1:0] e0,
  output dbt_pkg::tok_info_t      t1,
  output logic [OFFSET_WIDTH-1:0] b1,
  output logic [OFFSET_WIDTH-1:0] e1
);
  import dbt_pkg::*;

  localparam int OW = OFFSET_WIDTH;

  phase_t            phase, phase_next;
  logic [OW-1:0]     token_start, token_start_next;
  logic [OW-1:0]     byte_offset;
  logic [63:0]       number_accum, number_accum_next;
  logic [6:0]        token_length, token_length_next;
  logic [55:0]       keyword_buffer, keyword_buffer_next;
  logic              string_quote, string_quote_next;
  logic              comment_open, comment_open_next;
  logic [5:0]        kw_kind;
  logic [OW-1:0]     p, p1;

  dbt_kw_match u_kw (.buffer(keyword_buffer), .length(token_length), .kind(kw_kind));

  assign p  = byte_offset;
  assign p1 = byte_offset + OW'(1);

  function automatic logic is_dig(input logic [7:0] x);
    return x >= "0" && x <= "9";
  endfunction
  function automatic logic is_id0(input logic [7:0] x);
    return (x >= "a" && x <= "z") || (x >= "A" && x <= "Z") || x == "_";
  endfunction
  function automatic logic [4:0] hex_v(input logic [7:0] x);
    if (is_dig(x)) return {1'b0, 4'(x - "0")};
    if (x >= "a" && x <= "f") return {1'b0, 4'(x - "a" + 8'd10)};
    if (x >= "A" && x <= "F") return {1'b0, 4'(x - "A" + 8'd10)};
    return 5'h10;
  endfunction

  // Saturating accumulate: radix 10 uses shifts and one add; the compare checks overflow.
  function automatic logic [63:0] accum(input logic [63:0] a, input logic hex,
                                        input logic [3:0] d);
    logic [67:0] prod;
    logic [67:0] sum;
    prod = hex ? {a, 4'd0} : ({a, 3'd0} + {3'd0, a, 1'b0});
    sum = prod + 68'(d);
    if (a > 64'(ValueMax) || sum > 68'(ValueMax)) return 64'(ValueMax);
    return sum[63:0];
  endfunction

  function automatic tok_info_t mk(input logic [5:0] k, input logic [62:0] v,
                                   input logic [1:0] e);
    tok_info_t t;
    t.kind = k;
    t.value = v;
    t.err = e;
    return t;
  endfunction

  // The one-character form of a pending operator.
  function automatic tok_info_t op1(input logic [7:0] f);
    case (f)
      "-":     return mk(K_MINUS, '0, E_NONE);
      "!":     return mk(K_BANG, '0, E_NONE);
      "=":     return mk(K_ASSIGN, '0, E_NONE);
      "<":     return mk(K_LT, '0, E_NONE);
      ">":     return mk(K_GT, '0, E_NONE);
      default: return mk(K_INVALID, '0, E_CHAR);
    endcase
  endfunction

  // Next state and up to two result transactions for this byte or end marker.
  always_comb begin
    logic       ending;
    logic       start;
    logic       is_num;
    logic [4:0] hv;
    logic [5:0] k2;
    tok_info_t  fin;
    logic       fin_v;
    tok_info_t  st;
    logic       st_v;
    phase_next          = phase;
    token_start_next    = token_start;
    number_accum_next   = number_accum;
    token_length_next   = token_length;
    keyword_buffer_next = keyword_buffer;
    string_quote_next   = string_quote;
    comment_open_next   = comment_open;
    ending = 1'b0;
    start  = 1'b0;
    fin    = mk(K_EOF, '0, E_NONE);
    fin_v  = 1'b0;
    st     = mk(K_EOF, '0, E_NONE);
    st_v   = 1'b0;
    hv     = hex_v(c);
    k2     = K_EOF;
    is_num = phase == PH_NUM_ZERO || phase == PH_NUM_DEC || phase == PH_NUM_HEX
          || phase == PH_NUM_FRAC || phase == PH_NUM_EXP_SIGN || phase == PH_NUM_EXP;
    n_out = 2'd0;
    t0 = fin; t1 = fin;
    b0 = token_start; e0 = p; b1 = p; e1 = p1;

    if (mode == MODE_END) begin
      // Flush the open token, then the end token.
      ending = 1'b1;
      fin_v = 1'b1;
      case (phase)
        PH_SLASH:  fin = mk(K_SLASH, '0, E_NONE);
        PH_IDENT:  fin = mk(kw_kind, (kw_kind == K_TRUE) ? 63'd1 : 63'd0, E_NONE);
        PH_STRING, PH_STR_ESC: fin = mk(K_INVALID, '0, E_UNTERM);
        PH_OP:     fin = op1(keyword_buffer[7:0]);
        default: begin
          if (is_num) begin
            if (32'(token_length) >= NUMBER_LIMIT) fin = mk(K_INVALID, '0, E_NUMBER);
            else if (phase == PH_NUM_FRAC || phase == PH_NUM_EXP_SIGN ||
                     phase == PH_NUM_EXP) fin = mk(K_FLOAT, '0, E_NONE);
            else fin = mk(K_INT, number_accum[62:0], E_NONE);
          end else begin
            fin_v = 1'b0;
          end
        end
      endcase
      st = mk(K_EOF, '0,
              (comment_open || phase == PH_BLOCK || phase == PH_BLOCK_STAR) ? E_UNTERM : E_NONE);
      st_v = 1'b1;
      b1 = p; e1 = p;
    end else begin
      case (phase)
        PH_SLASH: begin
          if (c == "/") phase_next = PH_LINE;
          else if (c == "*") begin
            phase_next = PH_BLOCK;
            comment_open_next = 1'b1;
          end else begin
            fin = mk(K_SLASH, '0, E_NONE); fin_v = 1'b1; start = 1'b1;
          end
        end
        PH_LINE: if (c == 8'h0a) phase_next = PH_TRIVIA;
        PH_BLOCK: if (c == "*") phase_next = PH_BLOCK_STAR;
        PH_BLOCK_STAR: begin
          if (c == "/") begin
            phase_next = PH_TRIVIA;
            comment_open_next = 1'b0;
          end else if (c != "*") phase_next = PH_BLOCK;
        end
        PH_IDENT: begin
          if (is_id0(c) || is_dig(c)) begin
            for (int j = 1; j < KwBytes; j++) begin
              if (token_length == 7'(j)) keyword_buffer_next[8*j +: 8] = c;
            end
            if (token_length != LengthMax) token_length_next = token_length + 7'd1;
          end else begin
            fin = mk(kw_kind, (kw_kind == K_TRUE) ? 63'd1 : 63'd0, E_NONE);
            fin_v = 1'b1; start = 1'b1;
          end
        end
        PH_STRING: begin
          if (c == (string_quote ? 8'h27 : 8'h22)) begin
            phase_next = PH_TRIVIA;
            fin = mk(K_STRING, '0, E_NONE); fin_v = 1'b1; e0 = p1;
          end else if (c == 8'h5c) phase_next = PH_STR_ESC;
          else if (c == 8'h0a) begin
            phase_next = PH_TRIVIA;
            fin = mk(K_INVALID, '0, E_UNTERM); fin_v = 1'b1;
          end
        end
        PH_STR_ESC: phase_next = PH_STRING;
        PH_OP: begin
          case ({keyword_buffer[7:0], c})
            {"-", ">"}: k2 = K_ARROW;
            {"!", "="}: k2 = K_NE;
            {"=", "="}: k2 = K_EQEQ;
            {"<", "="}: k2 = K_LE;
            {">", "="}: k2 = K_GE;
            {"&", "&"}: k2 = K_ANDAND;
            {"|", "|"}: k2 = K_OROR;
            default:    k2 = K_EOF;
          endcase
          fin_v = 1'b1;
          if (k2 != K_EOF) begin
            phase_next = PH_TRIVIA;
            fin = mk(k2, '0, E_NONE); e0 = p1;
          end else begin
            fin = op1(keyword_buffer[7:0]); start = 1'b1;
          end
        end
        PH_TRIVIA: start = 1'b1;
        default: begin
          // Number phases.
          logic cont;
          cont = 1'b1;
          if (phase == PH_NUM_ZERO && (c == "x" || c == "X")) phase_next = PH_NUM_HEX;
          else if (phase == PH_NUM_ZERO || phase == PH_NUM_DEC) begin
            if (is_dig(c)) begin
              phase_next = PH_NUM_DEC;
              number_accum_next = accum(number_accum, 1'b0, c[3:0]);
            end else if (c == ".") phase_next = PH_NUM_FRAC;
            else if (c == "e" || c == "E") phase_next = PH_NUM_EXP_SIGN;
            else cont = 1'b0;
          end else if (phase == PH_NUM_FRAC) begin
            if (c == "e" || c == "E") phase_next = PH_NUM_EXP_SIGN;
            else if (!is_dig(c)) cont = 1'b0;
          end else if (phase == PH_NUM_EXP_SIGN) begin
            if (c == "+" || c == "-" || is_dig(c)) phase_next = PH_NUM_EXP;
            else cont = 1'b0;
          end else if (phase == PH_NUM_EXP) begin
            if (!is_dig(c)) cont = 1'b0;
          end else begin
            if (!hv[4]) number_accum_next = accum(number_accum, 1'b1, hv[3:0]);
            else cont = 1'b0;
          end
          if (cont) begin
            if (token_length != LengthMax) token_length_next = token_length + 7'd1;
          end else begin
            fin_v = 1'b1; start = 1'b1;
            if (32'(token_length) >= NUMBER_LIMIT) fin = mk(K_INVALID, '0, E_NUMBER);
            else if (phase == PH_NUM_FRAC || phase == PH_NUM_EXP_SIGN ||
                     phase == PH_NUM_EXP) fin = mk(K_FLOAT, '0, E_NONE);
            else fin = mk(K_INT, number_accum[62:0], E_NONE);
          end
        end
      endcase

      // A new token starts on this byte.
      if (start) begin
        phase_next = PH_TRIVIA;
        token_start_next = p;
        token_length_next = 7'd1;
        number_accum_next = '0;
        keyword_buffer_next = {48'd0, c};
        st_v = 1'b1;
        if (c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a) st_v = 1'b0;
        else if (is_id0(c)) begin
          phase_next = PH_IDENT; st_v = 1'b0;
        end else if (is_dig(c)) begin
          number_accum_next = 64'(c[3:0]);
          phase_next = (c == "0") ? PH_NUM_ZERO : PH_NUM_DEC;
          st_v = 1'b0;
        end else begin
          case (c)
            8'h22: begin string_quote_next = 1'b0; phase_next = PH_STRING; st_v = 1'b0; end
            8'h27: begin string_quote_next = 1'b1; phase_next = PH_STRING; st_v = 1'b0; end
            "/": begin phase_next = PH_SLASH; st_v = 1'b0; end
            "-", "!", "=", "<", ">", "&", "|": begin phase_next = PH_OP; st_v = 1'b0; end
            "{": st = mk(K_LBRACE, '0, E_NONE);
            "}": st = mk(K_RBRACE, '0, E_NONE);
            "(": st = mk(K_LPAREN, '0, E_NONE);
            ")": st = mk(K_RPAREN, '0, E_NONE);
            "[": st = mk(K_LBRACK, '0, E_NONE);
            "]": st = mk(K_RBRACK, '0, E_NONE);
            ",": st = mk(K_COMMA, '0, E_NONE);
            ";": st = mk(K_SEMI, '0, E_NONE);
            ".": st = mk(K_DOT, '0, E_NONE);
            ":": st = mk(K_COLON, '0, E_NONE);
            "*": st = mk(K_STAR, '0, E_NONE);
            "+": st = mk(K_PLUS, '0, E_NONE);
            "%": st = mk(K_PERCENT, '0, E_NONE);
            default: st = mk(K_INVALID, '0, E_CHAR);
          endcase
        end
      end
    end

    // Pack results in order.
    if (fin_v) begin
      t0 = fin;
      t1 = st;
      n_out = st_v ? 2'd2 : 2'd1;
    end else if (st_v) begin
      t0 = st; b0 = b1; e0 = e1;
      n_out = 2'd1;
    end
    if (ending) phase_next = PH_TRIVIA;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst || (go && mode == MODE_END)) begin
      phase          <= PH_TRIVIA;
      token_start    <= '0;
      byte_offset    <= '0;
      number_accum   <= '0;
      token_length   <= '0;
      keyword_buffer <= '0;
      string_quote   <= 1'b0;
      comment_open   <= 1'b0;
    end else if (go) begin
      phase          <= phase_next;
      token_start    <= token_start_next;
      byte_offset    <= p1;
      number_accum   <= number_accum_next;
      token_length   <= token_length_next;
      keyword_buffer <= keyword_buffer_next;
      string_quote   <= string_quote_next;
      comment_open   <= comment_open_next;
    end
  end
endmodule
`default_nettype wire

/* sv/dbt_checker.sv */
// Port-level checker for the byte tokenizer, bound to the top level.
// Depends on dbt_pkg.
`default_nettype none
module dbt_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_kind,
  input logic [1:0] out_err,
  input logic       out_last
);
  import dbt_pkg::*;

  // An end-of-file transaction always closes its run.
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == K_EOF |-> out_last) else $error("eof not last");

  // Bad-number code only on invalid tokens.
  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_err == E_NUMBER |-> out_kind == K_INVALID)
    else $error("bad number on valid kind");

  // Nothing comes out right after reset.
  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("output after reset");

  // A held result stays put while stalled.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind))
    else $error("result dropped");
endmodule

bind dsl_byte_tokenizer dbt_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_kind(out_ch.token_kind), .out_err(out_ch.error_code),
  .out_last(out_ch.last_of_run)
);
`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for dsl_byte_tokenizer: random byte streams with random idling.
// Depends on dbt_pkg, dbt_stream_if and the dsl_byte_tokenizer RTL.
`timescale 1ns / 100ps
module tb;
  import dbt_pkg::*;

  typedef struct {
    logic [5:0]  kind;
    logic [31:0] span_b;
    logic [31:0] span_e;
    logic [62:0] value;
    logic [1:0]  err;
    logic        last;
  } token_t;

  // Scoreboard: predicts the tokens of each accepted byte and checks the result channel.
  class token_scoreboard;
    token_t expected_tokens[$];
    token_t step_tokens[$];
    int errors;
    string kw_names[14];
    phase_t ph;
    logic [31:0] tok_start;
    logic [31:0] offset;
    logic [63:0] accum;
    int unsigned tok_len;
    logic [55:0] kw_buf;
    logic single_quote;
    logic comment_open;

    function new();
      kw_names = '{"rule", "allow", "deny", "require", "weight", "reason", "with",
                   "and", "or", "not", "true", "false", "if", "else"};
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      ph = PH_TRIVIA;
      tok_start = '0;
      offset = '0;
      accum = '0;
      tok_len = 0;
      kw_buf = '0;
      single_quote = 1'b0;
      comment_open = 1'b0;
    endfunction

    function void report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endfunction

    function void put(logic [5:0] k, logic [31:0] b, logic [31:0] e, logic [63:0] v,
                      logic [1:0] err);
      token_t t;
      t.kind = k;
      t.span_b = b;
      t.span_e = e;
      t.value = v[62:0];
      t.err = err;
      t.last = 1'b0;
      step_tokens.push_back(t);
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_ident_start(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function int hex_digit(logic [7:0] c);
      if (is_digit(c)) return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
    endfunction

    function void bump();
      if (tok_len < 127) tok_len++;
    endfunction

    function void accumulate(logic [63:0] radix, logic [63:0] d);
      logic [63:0] vmax;
      vmax = 64'h7FFF_FFFF_FFFF_FFFF;
      if (accum > (vmax - d) / radix) accum = vmax;
      else accum = accum * radix + d;
    endfunction

    function logic [5:0] keyword_kind();
      bit same;
      for (int i = 0; i < 14; i++) begin
        if (kw_names[i].len() != tok_len) continue;
        same = 1;
        for (int j = 0; j < kw_names[i].len(); j++)
          if (kw_buf[8*j +: 8] != kw_names[i][j]) same = 0;
        if (same) return K_FIRST_KW + 6'(i);
      end
      return K_IDENT;
    endfunction

    function void finish_ident(logic [31:0] e);
      logic [5:0] k;
      k = keyword_kind();
      ph = PH_TRIVIA;
      put(k, tok_start, e, (k == K_TRUE) ? 64'd1 : 64'd0, E_NONE);
    endfunction

    function void finish_number(logic [31:0] e);
      bit is_int;
      is_int = ph == PH_NUM_ZERO || ph == PH_NUM_DEC || ph == PH_NUM_HEX;
      ph = PH_TRIVIA;
      if (tok_len >= NumberLimitDefault) put(K_INVALID, tok_start, e, 0, E_NUMBER);
      else if (!is_int) put(K_FLOAT, tok_start, e, 0, E_NONE);
      else put(K_INT, tok_start, e, accum, E_NONE);
    endfunction

    // One-character form of a pending operator.
    function void finish_op(logic [31:0] e);
      logic [5:0] k;
      logic [1:0] err;
      k = K_INVALID;
      err = E_NONE;
      ph = PH_TRIVIA;
      case (kw_buf[7:0])
        "-": k = K_MINUS;
        "!": k = K_BANG;
        "=": k = K_ASSIGN;
        "<": k = K_LT;
        ">": k = K_GT;
        default: err = E_CHAR;
      endcase
      put(k, tok_start, e, 0, err);
    endfunction

    function void start_token(logic [7:0] c, logic [31:0] p);
      logic [5:0] k;
      ph = PH_TRIVIA;
      tok_start = p;
      tok_len = 1;
      accum = '0;
      kw_buf = {48'd0, c};
      if (c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a) return;
      if (is_ident_start(c)) begin
        ph = PH_IDENT;
        return;
      end
      if (is_digit(c)) begin
        accum = 64'(c - "0");
        ph = (c == "0") ? PH_NUM_ZERO : PH_NUM_DEC;
        return;
      end
      case (c)
        "\"": begin single_quote = 0; ph = PH_STRING; return; end
        "'": begin single_quote = 1; ph = PH_STRING; return; end
        "/": begin ph = PH_SLASH; return; end
        "-", "!", "=", "<", ">", "&", "|": begin ph = PH_OP; return; end
        "{": k = K_LBRACE;
        "}": k = K_RBRACE;
        "(": k = K_LPAREN;
        ")": k = K_RPAREN;
        "[": k = K_LBRACK;
        "]": k = K_RBRACK;
        ",": k = K_COMMA;
        ";": k = K_SEMI;
        ".": k = K_DOT;
        ":": k = K_COLON;
        "*": k = K_STAR;
        "+": k = K_PLUS;
        "%": k = K_PERCENT;
        default: begin
          put(K_INVALID, p, p + 1, 0, E_CHAR);
          return;
        end
      endcase
      put(k, p, p + 1, 0, E_NONE);
    endfunction

    function void scan_byte(logic [7:0] c, logic [31:0] p);
      logic [7:0] q;
      logic [5:0] k;
      int h;
      case (ph)
        PH_SLASH: begin
          if (c == "/") begin ph = PH_LINE; return; end
          if (c == "*") begin ph = PH_BLOCK; comment_open = 1; return; end
          put(K_SLASH, tok_start, p, 0, E_NONE);
          start_token(c, p);
          return;
        end
        PH_LINE: begin
          if (c == "\n") ph = PH_TRIVIA;
          return;
        end
        PH_BLOCK: begin
          if (c == "*") ph = PH_BLOCK_STAR;
          return;
        end
        PH_BLOCK_STAR: begin
          if (c == "/") begin ph = PH_TRIVIA; comment_open = 0; end
          else if (c != "*") ph = PH_BLOCK;
          return;
        end
        PH_IDENT: begin
          if (is_ident_start(c) || is_digit(c)) begin
            if (tok_len < 7) kw_buf[8*tok_len +: 8] = c;
            bump();
            return;
          end
          finish_ident(p);
          start_token(c, p);
          return;
        end
        PH_STRING: begin
          q = single_quote ? "'" : "\"";
          if (c == q) begin
            ph = PH_TRIVIA;
            put(K_STRING, tok_start, p + 1, 0, E_NONE);
          end else if (c == "\\") begin
            ph = PH_STR_ESC;
          end else if (c == "\n") begin
            ph = PH_TRIVIA;
            put(K_INVALID, tok_start, p, 0, E_UNTERM);
          end
          return;
        end
        PH_STR_ESC: begin
          ph = PH_STRING;
          return;
        end
        PH_NUM_ZERO, PH_NUM_DEC: begin
          if (ph == PH_NUM_ZERO && (c == "x" || c == "X")) begin
            ph = PH_NUM_HEX; bump(); return;
          end
          ph = PH_NUM_DEC;
          if (is_digit(c)) begin accumulate(10, 64'(c - "0")); bump(); return; end
          if (c == ".") begin ph = PH_NUM_FRAC; bump(); return; end
          if (c == "e" || c == "E") begin ph = PH_NUM_EXP_SIGN; bump(); return; end
        end
        PH_NUM_FRAC: begin
          if (is_digit(c)) begin bump(); return; end
          if (c == "e" || c == "E") begin ph = PH_NUM_EXP_SIGN; bump(); return; end
        end
        PH_NUM_EXP_SIGN: begin
          if (c == "+" || c == "-" || is_digit(c)) begin ph = PH_NUM_EXP; bump(); return; end
        end
        PH_NUM_EXP: begin
          if (is_digit(c)) begin bump(); return; end
        end
        PH_NUM_HEX: begin
          h = hex_digit(c);
          if (h >= 0) begin accumulate(16, 64'(h)); bump(); return; end
        end
        PH_OP: begin
          k = '0;
          case ({kw_buf[7:0], c})
            {"-", ">"}: k = K_ARROW;
            {"!", "="}: k = K_NE;
            {"=", "="}: k = K_EQEQ;
            {"<", "="}: k = K_LE;
            {">", "="}: k = K_GE;
            {"&", "&"}: k = K_ANDAND;
            {"|", "|"}: k = K_OROR;
            default: k = '0;
          endcase
          if (k != '0) begin
            ph = PH_TRIVIA;
            put(k, tok_start, p + 1, 0, E_NONE);
          end else begin
            finish_op(p);
            start_token(c, p);
          end
          return;
        end
        default: begin
          start_token(c, p);
          return;
        end
      endcase
      // A number ended on this byte.
      finish_number(p);
      start_token(c, p);
    endfunction

    function void end_of_buffer();
      logic [1:0] err;
      err = E_NONE;
      case (ph)
        PH_SLASH: put(K_SLASH, tok_start, offset, 0, E_NONE);
        PH_BLOCK, PH_BLOCK_STAR: err = E_UNTERM;
        PH_IDENT: finish_ident(offset);
        PH_STRING, PH_STR_ESC: put(K_INVALID, tok_start, offset, 0, E_UNTERM);
        PH_NUM_ZERO, PH_NUM_DEC, PH_NUM_HEX, PH_NUM_FRAC, PH_NUM_EXP_SIGN, PH_NUM_EXP:
          finish_number(offset);
        PH_OP: finish_op(offset);
        default: ;
      endcase
      if (comment_open) err = E_UNTERM;
      put(K_EOF, offset, offset, 0, err);
      clear_state();
    endfunction

    function void note_input(logic m, logic [7:0] c);
      logic [31:0] p;
      step_tokens.delete();
      if (m == MODE_END) begin
        end_of_buffer();
      end else begin
        p = offset;
        scan_byte(c, p);
        offset = p + 1;
      end
      if (step_tokens.size() > 0) step_tokens[$].last = 1'b1;
      foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    endfunction

    function void check_result(token_t got);
      token_t w;
      if (expected_tokens.size() == 0) begin
        report($sformatf("unexpected token kind %0d", got.kind));
        return;
      end
      w = expected_tokens.pop_front();
      if (got.kind !== w.kind)
        report($sformatf("kind %0d, want %0d", got.kind, w.kind));
      if (got.span_b !== w.span_b)
        report($sformatf("span_begin %0d, want %0d", got.span_b, w.span_b));
      if (got.span_e !== w.span_e)
        report($sformatf("span_end %0d, want %0d", got.span_e, w.span_e));
      if (got.value !== w.value)
        report($sformatf("int_value %0h, want %0h", got.value, w.value));
      if (got.err !== w.err)
        report($sformatf("error_code %0d, want %0d", got.err, w.err));
      if (got.last !== w.last)
        report($sformatf("last_of_run %0d, want %0d", got.last, w.last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int idle_cycles = 0;
  int out_stall = 0;
  bit no_idle = 0;
  token_scoreboard sb = new();
  logic [8:0] stim[$];

  dbt_in_if in_ch (.clk(clk));
  dbt_out_if #(.OFFSET_WIDTH(32)) out_ch (.clk(clk));

  dsl_byte_tokenizer i_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  // Clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result-side ready with random stalls, plus the transaction monitor and watchdog.
  always @(posedge clk) begin
    token_t got;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) sb.note_input(in_ch.mode, in_ch.byte_in);
      if (out_ch.valid && out_ch.ready) begin
        got.kind = out_ch.token_kind;
        got.span_b = out_ch.span_begin;
        got.span_e = out_ch.span_end;
        got.value = out_ch.int_value;
        got.err = out_ch.error_code;
        got.last = out_ch.last_of_run;
        sb.check_result(got);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 3000) begin
        $display("dsl_byte_tokenizer verification failed");
        $finish;
      end
    end
    if (out_stall > 0) begin
      out_ch.ready <= 1'b0;
      out_stall--;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 9) < 3) out_stall = gap_len();
    end
  end

  function void add_text(string s);
    for (int i = 0; i < s.len(); i++) stim.push_back({MODE_BYTE, s[i]});
  endfunction

  function void add_byte(logic [7:0] c);
    stim.push_back({MODE_BYTE, c});
  endfunction

  function void add_end();
    stim.push_back({MODE_END, 8'($urandom_range(0, 255))});
  endfunction

  function logic [7:0] ident_char();
    string set;
    set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  function void add_digits(int n);
    for (int i = 0; i < n; i++) add_byte(8'("0" + $urandom_range(0, 9)));
  endfunction

  // One well-formed or deliberately broken lexical fragment with random content.
  function void add_fragment();
    string puncts[30];
    string hex_set;
    int n;
    puncts = '{"{", "}", "(", ")", "[", "]", ",", ";", ".", "->", ":", "*", "==", "!=",
               "<", "<=", ">", ">=", "+", "-", "/", "%", "!", "&&", "||", "=", "&", "|",
               "-", "="};
    hex_set = "0123456789abcdefABCDEFxg";
    case ($urandom_range(0, 15))
      0: begin
        add_text(sb.kw_names[$urandom_range(0, 13)]);
        if ($urandom_range(0, 3) == 0) add_byte(ident_char());
      end
      1: begin
        add_byte($urandom_range(0, 1) ? "_" : 8'("a" + $urandom_range(0, 25)));
        n = $urandom_range(0, 9);
        for (int i = 0; i < n; i++) add_byte(ident_char());
      end
      2: begin
        add_byte(8'("1" + $urandom_range(0, 8)));
        add_digits($urandom_range(0, 22));
      end
      3: begin
        add_text($urandom_range(0, 1) ? "0x" : "0X");
        n = $urandom_range(0, 18);
        for (int i = 0; i < n; i++) add_byte(hex_set[$urandom_range(0, 21)]);
      end
      4: begin
        add_digits($urandom_range(1, 4));
        if ($urandom_range(0, 1)) begin add_byte("."); add_digits($urandom_range(0, 3)); end
        if ($urandom_range(0, 1)) begin
          add_byte($urandom_range(0, 1) ? "e" : "E");
          n = $urandom_range(0, 3);
          if (n == 1) add_byte("+");
          if (n == 2) add_byte("-");
          add_digits($urandom_range(0, 3));
        end
      end
      5: begin
        logic [7:0] q;
        q = $urandom_range(0, 1) ? "'" : "\"";
        add_byte(q);
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 7))
            0: begin add_byte("\\"); add_byte(8'($urandom_range(0, 255))); end
            1: add_byte(q == "'" ? "\"" : "'");
            2: add_byte(8'($urandom_range(128, 255)));
            default: add_byte(ident_char());
          endcase
        end
        case ($urandom_range(0, 9))
          0: add_byte("\n");
          1: add_end();
          default: add_byte(q);
        endcase
      end
      6: begin
        add_text("//");
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) add_byte(ident_char());
        add_byte("\n");
      end
      7: begin
        add_text("/*");
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) add_byte($urandom_range(0, 2) ? ident_char() : "*");
        if ($urandom_range(0, 7) == 0) add_end();
        else add_text("*/");
      end
      8, 9: add_text(puncts[$urandom_range(0, 29)]);
      10: add_byte(8'($urandom_range(0, 255)));
      11: begin
        if ($urandom_range(0, 5) == 0) begin
          add_byte("9");
          add_digits($urandom_range(60, 66));
        end else add_byte(" ");
      end
      12: if ($urandom_range(0, 2) == 0) add_end();
      13: add_byte("/");
      14: begin
        add_text(puncts[$urandom_range(0, 29)]);
        add_end();
      end
      default: add_byte(" ");
    endcase
  endfunction

  task automatic send_item(logic [8:0] item);
    int g;
    in_ch.valid <= 1'b1;
    in_ch.mode <= item[8];
    in_ch.byte_in <= item[7:0];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_BYTE;
    in_ch.byte_in = 8'h00;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: escapes, newline in string, hex without digits, incomplete exponent,
    // saturation, lone ampersand and bar, unknown byte, lone slash, end in comment.
    add_text("true x_9 'a\\'b' \"c\n \"d\\\n\" 0x 1e+ 0x7fffffffffffffffff");
    add_text(" & | @ / ->");
    add_byte(8'hff);
    add_byte(8'h00);
    add_text("/*");
    add_end();
    add_text("\"s\\");
    add_end();

    while (stim.size() < 820) begin
      add_fragment();
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 3))
          0: add_byte(" ");
          1: add_byte(8'h09);
          2: add_byte(8'h0d);
          default: add_byte(8'h0a);
        endcase
      end
    end
    add_end();

    foreach (stim[i]) begin
      if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      // Hold off once until the result channel has caught up.
      if (i == 400) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_tokens.size() > 0) @(posedge clk);
      end
      send_item(stim[i]);
    end
    in_ch.valid <= 1'b0;

    while (sb.expected_tokens.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_tokens.size() == 0) begin
      $display("dsl_byte_tokenizer verification clean");
    end else begin
      $display("dsl_byte_tokenizer verification failed");
    end
    $finish;
  end
endmodule

/* filelist.f */
sv/dbt_pkg.sv
sv/dbt_stream_if.sv
sv/dbt_kw_match.sv
sv/dbt_out_fifo.sv
sv/dbt_scanner.sv
sv/dsl_byte_tokenizer.sv
sv/dbt_checker.sv
tb/sv/tb.sv
